/* rtl/core/rns_modular_alu_special_primes_macros.svh */
// Assertion macros for the modular ALU core files; only rmasp_final uses them.
`ifndef RNS_MODULAR_ALU_SPECIAL_PRIMES_MACROS_SVH
`define RNS_MODULAR_ALU_SPECIAL_PRIMES_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define RMASP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Expression must never be true outside reset.
`define RMASP_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

/* rtl/core/rmasp_pkg.sv */
// Types, constants and helper functions for the Solinas-prime modular ALU.
package rmasp_pkg;

   // q = 2^k1 - 2^k2 + 1
   localparam int K1_A = 24;
   localparam int K2_A = 14;
   localparam int K1_B = 26;
   localparam int K2_B = 16;
   localparam int K1_C = 31;
   localparam int K2_C = 24;

   // Enough folds to bring any 64-bit value below 2^k1 for all three primes
   localparam int NUM_FOLDS = 7;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_RED = 2'd3;

   localparam logic [1:0] SEL_A   = 2'd0;
   localparam logic [1:0] SEL_B   = 2'd1;
   localparam logic [1:0] SEL_C   = 2'd2;
   localparam logic [1:0] SEL_ALT = 2'd3;   // aliases SEL_C

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  sel;
      logic [31:0] a;
      logic [31:0] b;
      logic [63:0] wide;
   } request_type;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  sel;
      logic        err;
   } stage_type;

   typedef struct packed {
      logic [30:0] residue;
      logic        range_error;
   } result_type;

   function automatic logic [30:0] prime_of(input logic [1:0] sel);
      logic [30:0] q;
      case (sel)
         SEL_A:   q = 31'((64'd1 << K1_A) - (64'd1 << K2_A) + 64'd1);
         SEL_B:   q = 31'((64'd1 << K1_B) - (64'd1 << K2_B) + 64'd1);
         default: q = 31'((64'd1 << K1_C) - (64'd1 << K2_C) + 64'd1);
      endcase
      return q;
   endfunction

   // hi*2^k1 + lo  ->  hi*(2^k2 - 1) + lo
   function automatic logic [63:0] fold_step(input logic [63:0] v, input logic [1:0] sel);
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] r;
      case (sel)
         SEL_A: begin
            hi = v >> K1_A;
            lo = 64'(v[K1_A-1:0]);
            r  = (hi << K2_A) - hi + lo;
         end
         SEL_B: begin
            hi = v >> K1_B;
            lo = 64'(v[K1_B-1:0]);
            r  = (hi << K2_B) - hi + lo;
         end
         default: begin
            hi = v >> K1_C;
            lo = 64'(v[K1_C-1:0]);
            r  = (hi << K2_C) - hi + lo;
         end
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/rmasp_front.sv */
// Front stage: operand check, add, subtract, multiply or wide-value pass-through, registered.
module rmasp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   output logic                 in_rdy,
   input  rmasp_pkg::request_type in_req,
   output logic                 out_vld,
   input  logic                 out_rdy,
   output rmasp_pkg::stage_type out_data
);
   import rmasp_pkg::*;

   logic        vld_ff, vld_in;
   stage_type   data_ff, data_in;
   logic [1:0]  sel_n;
   logic [30:0] q;
   logic [63:0] prod;
   logic [63:0] value;
   logic        bad;

   assign sel_n = (in_req.sel == SEL_ALT) ? SEL_C : in_req.sel;
   assign q     = prime_of(sel_n);
   // upper halves are zero, so this stays a 32x32 product
   assign prod  = 64'(in_req.a) * 64'(in_req.b);
   assign bad   = (in_req.op != OP_RED) &&
                  ((in_req.a >= {1'b0, q}) || (in_req.b >= {1'b0, q}));

   always_comb begin
      case (in_req.op)
         OP_ADD: value = 64'(in_req.a) + 64'(in_req.b);
         OP_SUB: value = 64'(in_req.a) + 64'(q) - 64'(in_req.b);
         OP_MUL: value = prod;
         OP_RED: value = in_req.wide;
      endcase
      data_in.value = bad ? 64'd0 : value;
      data_in.sel   = sel_n;
      data_in.err   = bad;
   end

   assign in_rdy = !vld_ff || out_rdy;
   assign vld_in = in_rdy ? in_vld : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy && in_vld) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

/* rtl/core/rmasp_fold.sv */
// One reduction fold stage: high bits folded back into the low part.
module rmasp_fold (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   output logic                 in_rdy,
   input  rmasp_pkg::stage_type in_data,
   output logic                 out_vld,
   input  logic                 out_rdy,
   output rmasp_pkg::stage_type out_data
);
   import rmasp_pkg::*;

   logic      vld_ff, vld_in;
   stage_type data_ff, data_in;

   always_comb begin
      data_in       = in_data;
      data_in.value = fold_step(in_data.value, in_data.sel);
   end

   assign in_rdy = !vld_ff || out_rdy;
   assign vld_in = in_rdy ? in_vld : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy && in_vld) begin
         data_ff <= data_in;
      end
   end

   assign out_vld  = vld_ff;
   assign out_data = data_ff;

endmodule

/* rtl/core/rmasp_final.sv */
// Final stage: conditional subtraction of q into the output register.
`include "rns_modular_alu_special_primes_macros.svh"

module rmasp_final (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   output logic                  in_rdy,
   input  rmasp_pkg::stage_type  in_data,
   output logic                  out_vld,
   input  logic                  out_rdy,
   output rmasp_pkg::result_type out_res
);
   import rmasp_pkg::*;

   logic        vld_ff, vld_in;
   result_type  res_ff, res_in;
   logic [1:0]  sel_ff;
   logic [30:0] q;

   assign q = prime_of(in_data.sel);

   always_comb begin
      // folded value is below 2q, so one subtraction suffices
      if (in_data.value >= 64'(q)) begin
         res_in.residue = 31'(in_data.value - 64'(q));
      end else begin
         res_in.residue = 31'(in_data.value);
      end
      res_in.range_error = in_data.err;
   end

   assign in_rdy = !vld_ff || out_rdy;
   assign vld_in = in_rdy ? in_vld : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy && in_vld) begin
         res_ff <= res_in;
         sel_ff <= in_data.sel;
      end
   end

   assign out_vld = vld_ff;
   assign out_res = res_ff;

   `RMASP_ASSERT(a_fold_bound, clock, reset, in_vld |-> (in_data.value < (64'(q) << 1)), "fold left value at or above 2q")
   `RMASP_ASSERT(a_residue_below_q, clock, reset, vld_ff |-> (res_ff.residue < prime_of(sel_ff)), "residue not below q")
   `RMASP_ASSERT_NEVER(a_err_zero, clock, reset, vld_ff && res_ff.range_error && (res_ff.residue != 31'd0), "range error with nonzero residue")

endmodule

/* rtl/core/rns_modular_alu_special_primes.sv */
// Modular ALU for the primes 2^24-2^14+1, 2^26-2^16+1 and 2^31-2^24+1.
// Usage:
//   Request channel req_*: tuser carries the operation (bits 1:0: 0 add,
//   1 subtract a-b, 2 multiply, 3 reduce) and the prime select (bits 3:2,
//   select 3 aliases select 2). tdata carries operand_a, operand_b and the
//   64-bit wide_value. Each request yields exactly one response on rsp_*:
//   tdata holds the residue in [0,q), tuser the range_error flag, set with
//   a zero residue when an add/sub/mul operand is not below q.
//   Each request passes through nine register stages: one front stage
//   (range check, add, subtract, 32x32 multiply), seven fold stages, one
//   final conditional-subtract stage that also serves as output register.
//   Throughput is one item per cycle while rsp_tready is high; each stage
//   holds one item and frees itself as soon as the next stage takes it,
//   so bubbles close up.
//   When rsp_tready is low the items stay in their stages and req_tready
//   drops once the pipeline is full; nothing is lost or repeated.
//   Reset (synchronous, active high) empties the pipeline; there is no
//   other state.
module rns_modular_alu_special_primes (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // operand_a[31:0], operand_b[63:32], wide_value[127:64]
   input  logic [3:0]   req_tuser,   // req_type[1:0], modulus_sel[3:2]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // residue[30:0], zero pad[31]
   output logic         rsp_tuser    // range_error
);
   import rmasp_pkg::*;

   request_type req;
   stage_type   stg_data [NUM_FOLDS+1];
   logic        stg_vld  [NUM_FOLDS+1];
   logic        stg_rdy  [NUM_FOLDS+1];
   result_type  res;

   assign req.op   = req_tuser[1:0];
   assign req.sel  = req_tuser[3:2];
   assign req.a    = req_tdata[31:0];
   assign req.b    = req_tdata[63:32];
   assign req.wide = req_tdata[127:64];

   rmasp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (req_tvalid),
      .in_rdy   (req_tready),
      .in_req   (req),
      .out_vld  (stg_vld[0]),
      .out_rdy  (stg_rdy[0]),
      .out_data (stg_data[0])
   );

   for (genvar i = 0; i < NUM_FOLDS; i++) begin : g_fold
      rmasp_fold u_fold (
         .clock    (clock),
         .reset    (reset),
         .in_vld   (stg_vld[i]),
         .in_rdy   (stg_rdy[i]),
         .in_data  (stg_data[i]),
         .out_vld  (stg_vld[i+1]),
         .out_rdy  (stg_rdy[i+1]),
         .out_data (stg_data[i+1])
      );
   end

   rmasp_final u_final (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (stg_vld[NUM_FOLDS]),
      .in_rdy   (stg_rdy[NUM_FOLDS]),
      .in_data  (stg_data[NUM_FOLDS]),
      .out_vld  (rsp_tvalid),
      .out_rdy  (rsp_tready),
      .out_res  (res)
   );

   assign rsp_tdata = {1'b0, res.residue};
   assign rsp_tuser = res.range_error;

endmodule
